### design/six_axis_bias_calibrator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the six-axis bias calibrator checker
// Each macro expects clk and rst_n in scope at the point of use.
// ----------------------------------------------------------------------------
`ifndef SIX_AXIS_BIAS_CALIBRATOR_ASSERT_SVH
`define SIX_AXIS_BIAS_CALIBRATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SBC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define SBC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/sbc_pkg.sv
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, widths and codes for the six-axis bias calibrator.
// ----------------------------------------------------------------------------
package sbc_pkg;

    // Sample and axis geometry
    localparam int SAMPLE_BITS  = 16;
    localparam int AXES         = 6;
    localparam int ACCEL_Z_AXIS = 2;

    // Configuration field widths
    localparam int CNT_W      = 10;
    localparam int ONE_G_W    = 15;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Accumulator holds up to 1023 full-scale samples
    localparam int SUM_W  = SAMPLE_BITS + CNT_W;
    // Offset is clamped to a range wide enough that saturation is unchanged
    localparam int OFS_W  = SAMPLE_BITS + 2;
    localparam int STEP_W = $clog2(SUM_W);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_G        = 2'd1;

    // Register reset values
    localparam logic [CNT_W-1:0]   COUNT_RESET = 10'd100;
    localparam logic [ONE_G_W-1:0] ONE_G_RESET = 15'd16384;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_RUN,
        ST_LOAD,
        ST_DIV,
        ST_WRITE
    } ctrl_state_t;

    // Input request
    typedef struct packed {
        logic                          op;
        logic signed [SAMPLE_BITS-1:0] accel_x;
        logic signed [SAMPLE_BITS-1:0] accel_y;
        logic signed [SAMPLE_BITS-1:0] accel_z;
        logic signed [SAMPLE_BITS-1:0] gyro_x;
        logic signed [SAMPLE_BITS-1:0] gyro_y;
        logic signed [SAMPLE_BITS-1:0] gyro_z;
    } in_item_t;

    // Result request
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] corr_accel_x;
        logic signed [SAMPLE_BITS-1:0] corr_accel_y;
        logic signed [SAMPLE_BITS-1:0] corr_accel_z;
        logic signed [SAMPLE_BITS-1:0] corr_gyro_x;
        logic signed [SAMPLE_BITS-1:0] corr_gyro_y;
        logic signed [SAMPLE_BITS-1:0] corr_gyro_z;
        logic                          calibrating;
        logic                          calib_done;
    } out_item_t;

    // Controls broadcast from the sequencer to every lane
    typedef struct packed {
        logic             accum;
        logic             restart;
        logic             div_load;
        logic             div_step;
        logic             div_write;
        logic [CNT_W-1:0] divisor;
    } lane_ctl_t;

    // Sequencer status toward the top level
    typedef struct packed {
        logic busy;
        logic summed;
        logic done;
    } ctrl_stat_t;

endpackage

### design/sbc_lane.sv
// ----------------------------------------------------------------------------
// sbc_lane
// One axis: bias correction with saturation, running sum, and a
// shift-subtract divider that turns the sum into the new offset.
// ----------------------------------------------------------------------------
module sbc_lane (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sbc_pkg::lane_ctl_t                    ctl,
    input  logic signed [sbc_pkg::SAMPLE_BITS-1:0] sample,
    input  logic [sbc_pkg::ONE_G_W-1:0]           adj,
    output logic signed [sbc_pkg::SAMPLE_BITS-1:0] corr
);
    import sbc_pkg::*;

    localparam int DIFF_W = OFS_W + 1;
    localparam int QS_W   = SUM_W + 1;

    localparam logic [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [OFS_W-1:0]       OFS_MAX = {1'b0, {(OFS_W-1){1'b1}}};
    localparam logic [OFS_W-1:0]       OFS_MIN = {1'b1, {(OFS_W-1){1'b0}}};

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic signed [OFS_W-1:0] ofs_reg;
    logic [OFS_W-1:0]        ofs_next;
    logic                    neg_reg;
    logic [SUM_W-1:0]        quo_reg;
    logic [SUM_W-1:0]        quo_next;
    logic [CNT_W-1:0]        rem_reg;
    logic [CNT_W-1:0]        rem_next;

    logic [SUM_W-1:0]  sample_ext;
    logic [DIFF_W-1:0] diff;
    logic [CNT_W:0]    shifted;
    logic              fits;
    logic [QS_W-1:0]   quo_signed;
    logic [QS_W-1:0]   ofs_full;

    // Subtract offset and saturate to the sample range
    always_comb
    begin
        diff = {{(DIFF_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample}
             - {ofs_reg[OFS_W-1], ofs_reg};
        if ((diff[DIFF_W-1:SAMPLE_BITS-1] == '0) || (diff[DIFF_W-1:SAMPLE_BITS-1] == '1))
        begin
            corr = diff[SAMPLE_BITS-1:0];
        end
        else
        begin
            corr = diff[DIFF_W-1] ? SAT_MIN : SAT_MAX;
        end
    end

    // Accumulate raw samples; a restart makes this sample the first
    always_comb
    begin
        sample_ext = {{(SUM_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
        sum_next   = ctl.restart ? sample_ext : (sum_reg + sample_ext);
    end

    // One restoring divide step on the magnitude
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[SUM_W-1]};
        fits     = (shifted >= {1'b0, ctl.divisor});
        rem_next = fits ? CNT_W'(shifted - {1'b0, ctl.divisor}) : shifted[CNT_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], fits};
    end

    // Restore the sign, drop the one-g term, clamp into the offset range
    always_comb
    begin
        quo_signed = neg_reg ? (QS_W'(0) - {1'b0, quo_reg}) : {1'b0, quo_reg};
        ofs_full   = quo_signed - {{(QS_W-ONE_G_W){1'b0}}, adj};
        if ((ofs_full[QS_W-1:OFS_W-1] == '0) || (ofs_full[QS_W-1:OFS_W-1] == '1))
        begin
            ofs_next = ofs_full[OFS_W-1:0];
        end
        else
        begin
            ofs_next = ofs_full[QS_W-1] ? OFS_MIN : OFS_MAX;
        end
    end

    // Hold sum and offset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            ofs_reg <= '0;
        end
        else
        begin
            if (ctl.accum)
            begin
                sum_reg <= sum_next;
            end
            if (ctl.div_write)
            begin
                ofs_reg <= ofs_next;
            end
        end
    end

    // Divider datapath
    always_ff @(posedge clk)
    begin
        if (ctl.div_load)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            quo_reg <= sum_reg[SUM_W-1] ? (SUM_W'(0) - sum_reg) : sum_reg;
            rem_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

endmodule

### design/sbc_ctrl.sv
// ----------------------------------------------------------------------------
// sbc_ctrl
// Calibration sequencer: run bookkeeping and the divide sequence
// shared by all lanes.
// ----------------------------------------------------------------------------
module sbc_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          start,
    input  logic [sbc_pkg::CNT_W-1:0]     cfg_count,
    input  logic [sbc_pkg::ONE_G_W-1:0]   cfg_one_g,
    output sbc_pkg::lane_ctl_t            ctl,
    output sbc_pkg::ctrl_stat_t           stat,
    output logic [sbc_pkg::ONE_G_W-1:0]   one_g
);
    import sbc_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    logic               active_reg;
    logic               active_next;
    logic [CNT_W-1:0]   taken_reg;
    logic [CNT_W-1:0]   taken_next;
    logic [CNT_W-1:0]   div_n_reg;
    logic [ONE_G_W-1:0] one_g_reg;
    logic [STEP_W-1:0]  step_reg;

    logic [CNT_W-1:0] n_eff;
    logic [CNT_W-1:0] taken_inc;
    logic             summed;
    logic             done;

    // Decide whether this request is summed and whether it ends the run
    always_comb
    begin
        n_eff     = (cfg_count == '0) ? CNT_W'(1) : cfg_count;
        summed    = start || active_reg;
        taken_inc = (start ? '0 : taken_reg) + CNT_W'(1);
        done      = summed && (taken_inc >= n_eff);

        taken_next  = taken_reg;
        active_next = active_reg;
        if (accept && summed)
        begin
            taken_next  = done ? '0 : taken_inc;
            active_next = !done;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (accept && done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl.accum     = accept && summed;
        ctl.restart   = accept && start;
        ctl.div_load  = (state_reg == ST_LOAD);
        ctl.div_step  = (state_reg == ST_DIV);
        ctl.div_write = (state_reg == ST_WRITE);
        ctl.divisor   = div_n_reg;
        stat.busy     = (state_reg != ST_RUN);
        stat.summed   = summed;
        stat.done     = done;
        one_g         = one_g_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RUN;
            active_reg <= 1'b0;
            taken_reg  <= '0;
            step_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            taken_reg  <= taken_next;
            step_reg   <= (state_reg == ST_DIV) ? (step_reg + STEP_W'(1)) : '0;
        end
    end

    // Latch divisor and one-g term for the divide that follows
    always_ff @(posedge clk)
    begin
        if (accept && done)
        begin
            div_n_reg <= n_eff;
            one_g_reg <= cfg_one_g;
        end
    end

endmodule

### design/six_axis_bias_calibrator.sv
// ----------------------------------------------------------------------------
// six_axis_bias_calibrator
// Per-axis bias removal for a six-axis inertial sample stream, with
// calibration by averaging raw samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one six-axis sample
//   per request. op = 1 starts a calibration run with that sample as first.
//   Output channel (out_valid / out_stall / out_data) returns one request per
//   input: each axis minus its offset, saturated, plus calibrating and
//   calib_done flags.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   the sample count per run (0 acts as 1), index 1 is one-g counts. Other
//   indexes are ignored. cfg_ready is always high; write only when idle.
// Timing:
//   A result is registered: it sits in the output register the cycle after
//   its sample is taken. One sample per cycle is accepted normally.
//   The sample that completes a run stalls the input while the sequencer
//   steps through its load, divide and write states; in the divide state
//   each lane's shift-subtract divider produces one quotient bit per cycle.
//   A stalled result holds in the output register; the input then stalls.
// Reset:
//   Offsets, sums and run state clear; count resets to 100, one-g to 16384.
// ----------------------------------------------------------------------------
module six_axis_bias_calibrator (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  sbc_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output sbc_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sbc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sbc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sbc_pkg::*;

    logic [CNT_W-1:0]   count_reg;
    logic [ONE_G_W-1:0] one_g_cfg_reg;

    logic       out_valid_reg;
    out_item_t  out_data_reg;
    out_item_t  out_data_next;

    logic       accept;
    lane_ctl_t  ctl;
    ctrl_stat_t stat;
    logic [ONE_G_W-1:0] one_g;

    logic signed [SAMPLE_BITS-1:0] sample_a [AXES];
    logic signed [SAMPLE_BITS-1:0] corr_a   [AXES];

    // Take a request when idle and the output register can move
    assign in_stall  = stat.busy || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Split the request into lanes
    assign sample_a[0] = in_data.accel_x;
    assign sample_a[1] = in_data.accel_y;
    assign sample_a[2] = in_data.accel_z;
    assign sample_a[3] = in_data.gyro_x;
    assign sample_a[4] = in_data.gyro_y;
    assign sample_a[5] = in_data.gyro_z;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= COUNT_RESET;
            one_g_cfg_reg <= ONE_G_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SAMPLE_COUNT: count_reg     <= cfg_data[CNT_W-1:0];
                CFG_ONE_G:        one_g_cfg_reg <= cfg_data[ONE_G_W-1:0];
                default:          ;
            endcase
        end
    end

    sbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .start     (in_data.op),
        .cfg_count (count_reg),
        .cfg_one_g (one_g_cfg_reg),
        .ctl       (ctl),
        .stat      (stat),
        .one_g     (one_g)
    );

    // One lane per axis; only accel z drops the one-g term
    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        sbc_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctl    (ctl),
            .sample (sample_a[g]),
            .adj    ((g == ACCEL_Z_AXIS) ? one_g : ONE_G_W'(0)),
            .corr   (corr_a[g])
        );
    end

    // Merge lane results and run flags into one result request
    always_comb
    begin
        out_data_next.corr_accel_x = corr_a[0];
        out_data_next.corr_accel_y = corr_a[1];
        out_data_next.corr_accel_z = corr_a[2];
        out_data_next.corr_gyro_x  = corr_a[3];
        out_data_next.corr_gyro_y  = corr_a[4];
        out_data_next.corr_gyro_z  = corr_a[5];
        out_data_next.calibrating  = stat.summed;
        out_data_next.calib_done   = stat.done;
    end

    // Output register: load on accept, drop when taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### design/sbc_checker.sv
// ----------------------------------------------------------------------------
// sbc_checker
// Port-level checks for the six-axis bias calibrator, bound to the top level.
// ----------------------------------------------------------------------------
`include "six_axis_bias_calibrator_assert.svh"

module sbc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_stall,
    input logic                              out_valid,
    input logic                              out_stall,
    input sbc_pkg::out_item_t                out_data
);
    import sbc_pkg::*;

    // A finished run is always a summed sample
    `SBC_ASSERT_NOW(a_done_is_summed, out_valid && out_data.calib_done, out_data.calibrating, "calib_done without calibrating")

    // Every accepted sample shows up in the output register next cycle
    `SBC_ASSERT_NEXT(a_accept_fills_out, in_valid && !in_stall, out_valid, "accepted request produced no result")

    // A blocked output register holds off new input
    `SBC_ASSERT_NOW(a_full_stalls_in, out_valid && out_stall, in_stall, "input taken while result is stalled")

    // A stalled result holds
    `SBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind six_axis_bias_calibrator sbc_checker u_sbc_checker (.*);

### dv/tb_six_axis_bias_calibrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_six_axis_bias_calibrator
// Self-checking bench for the six-axis bias calibrator. A queue of samples
// feeds a clocked driver; every accepted sample runs through a local bias
// predictor whose corrected result is queued and compared field by field
// with the block's output. Directed cases cover the extremes, restarts, a
// count lowered mid-run and a zero count; random calibration runs follow
// under several register settings, with random stalls on both sides and one
// long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_six_axis_bias_calibrator;

    import sbc_pkg::*;

    localparam logic            OP_SAMPLE = 1'b0;
    localparam logic            OP_START  = 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    localparam logic signed [SAMPLE_BITS-1:0] LANE_MAX = 16'sh7fff;
    localparam logic signed [SAMPLE_BITS-1:0] LANE_MIN = 16'sh8000;

    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 4000;
    localparam int HOLD_AT       = 250;
    localparam int HOLD_CYCLES   = 300;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_item_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_item_t              out_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Stimulus and expectation stores
    in_item_t  sample_q[$];
    out_item_t corrected_q[$];
    int        items_queued = 0;
    int        results_seen = 0;
    int        accepted_cnt = 0;
    int        fault_cnt    = 0;

    // Idling control
    int gap_left   = 0;
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_fired = 1'b0;
    bit quiet_tail = 1'b0;
    out_item_t want_item;

    // Predictor state and register shadows
    longint              sum_model[AXES];
    longint              ofs_model[AXES];
    logic [CNT_W-1:0]    taken_model   = '0;
    bit                  active_model  = 1'b0;
    logic [CNT_W-1:0]    count_shadow  = COUNT_RESET;
    logic [ONE_G_W-1:0]  one_g_shadow  = ONE_G_RESET;

    // Bias that random samples cluster around
    longint bias_center[AXES];

    six_axis_bias_calibrator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Saturate a difference to the signed lane range
    function automatic logic [SAMPLE_BITS-1:0] clamp_lane(longint v);
        if (v > 32767)
        begin
            return LANE_MAX;
        end
        if (v < -32768)
        begin
            return LANE_MIN;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // Work out the corrected result of one sample and advance the bias state
    task automatic predict_corrected(in_item_t s);
        longint                 raw[AXES];
        logic [SAMPLE_BITS-1:0] corr[AXES];
        out_item_t              r;
        longint                 n;
        raw[0] = $signed(s.accel_x);
        raw[1] = $signed(s.accel_y);
        raw[2] = $signed(s.accel_z);
        raw[3] = $signed(s.gyro_x);
        raw[4] = $signed(s.gyro_y);
        raw[5] = $signed(s.gyro_z);
        n = (count_shadow == 0) ? 1 : longint'(count_shadow);
        // Outputs use the offsets from before this sample
        for (int i = 0; i < AXES; i++)
        begin
            corr[i] = clamp_lane(raw[i] - ofs_model[i]);
        end
        r.corr_accel_x = corr[0];
        r.corr_accel_y = corr[1];
        r.corr_accel_z = corr[2];
        r.corr_gyro_x  = corr[3];
        r.corr_gyro_y  = corr[4];
        r.corr_gyro_z  = corr[5];
        r.calibrating  = 1'b0;
        r.calib_done   = 1'b0;
        if (s.op == OP_START)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                sum_model[i] = 0;
            end
            taken_model  = '0;
            active_model = 1'b1;
        end
        if (active_model)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                sum_model[i] += raw[i];
            end
            taken_model   = taken_model + 1'b1;
            r.calibrating = 1'b1;
            if (longint'(taken_model) >= n)
            begin
                for (int i = 0; i < AXES; i++)
                begin
                    ofs_model[i] = sum_model[i] / n;
                end
                ofs_model[ACCEL_Z_AXIS] -= longint'(one_g_shadow);
                taken_model  = '0;
                active_model = 1'b0;
                r.calib_done = 1'b1;
            end
        end
        corrected_q.push_back(r);
    endtask

    function automatic void report_fault(string msg);
        fault_cnt++;
        if (fault_cnt <= 10)
        begin
            $display("mismatch %0d at %0t: %s", fault_cnt, $time, msg);
        end
    endfunction

    function automatic void check_field(string name, logic [SAMPLE_BITS-1:0] want,
                                        logic [SAMPLE_BITS-1:0] got);
        if (want !== got)
        begin
            report_fault($sformatf("%s expected %h got %h", name, want, got));
        end
    endfunction

    function automatic in_item_t mk(logic op, logic [15:0] ax, logic [15:0] ay,
                                    logic [15:0] az, logic [15:0] gx,
                                    logic [15:0] gy, logic [15:0] gz);
        in_item_t it;
        it.op      = op;
        it.accel_x = ax;
        it.accel_y = ay;
        it.accel_z = az;
        it.gyro_x  = gx;
        it.gyro_y  = gy;
        it.gyro_z  = gz;
        return it;
    endfunction

    // Random sample: mostly bias plus noise, some full-range, some extremes, some zero
    function automatic in_item_t gen_item(logic op);
        logic [15:0] v[AXES];
        int          k;
        longint      t;
        for (int i = 0; i < AXES; i++)
        begin
            k = $urandom_range(0, 99);
            if (k < 70)
            begin
                t    = bias_center[i] + int'($urandom_range(0, 64)) - 32;
                v[i] = t[15:0];
            end
            else if (k < 85)
            begin
                v[i] = 16'($urandom);
            end
            else if (k < 95)
            begin
                v[i] = $urandom_range(0, 1) ? LANE_MAX : LANE_MIN;
            end
            else
            begin
                v[i] = '0;
            end
        end
        return mk(op, v[0], v[1], v[2], v[3], v[4], v[5]);
    endfunction

    task automatic queue_item(in_item_t it);
        sample_q.push_back(it);
        items_queued++;
    endtask

    function automatic void new_bias();
        for (int i = 0; i < AXES; i++)
        begin
            bias_center[i] = longint'($signed(16'($urandom)));
        end
    endfunction

    // Mostly complete calibration runs, some cut short, some loose samples
    task automatic queue_runs(int n_items, int run_len);
        int made;
        int k;
        int extra;
        made = 0;
        while (made < n_items)
        begin
            k = $urandom_range(0, 99);
            if (k < 75)
            begin
                extra = $urandom_range(0, 4);
                queue_item(gen_item(OP_START));
                repeat (run_len - 1 + extra)
                begin
                    queue_item(gen_item(OP_SAMPLE));
                end
                made += run_len + extra;
            end
            else if (k < 90)
            begin
                extra = $urandom_range(0, run_len - 1);
                queue_item(gen_item(OP_START));
                repeat (extra)
                begin
                    queue_item(gen_item(OP_SAMPLE));
                end
                made += 1 + extra;
            end
            else
            begin
                extra = $urandom_range(1, 6);
                repeat (extra)
                begin
                    queue_item(gen_item(OP_SAMPLE));
                end
                made += extra;
            end
        end
    endtask

    // Wait for every result, then let the divider finish
    task automatic drain();
        while (results_seen < items_queued)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            CFG_SAMPLE_COUNT: count_shadow = val[CNT_W-1:0];
            CFG_ONE_G:        one_g_shadow = val[ONE_G_W-1:0];
            default:          ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int count, int one_g);
        write_reg(CFG_SAMPLE_COUNT, CFG_DATA_W'(count));
        write_reg(CFG_ONE_G, CFG_DATA_W'(one_g));
    endtask

    // Driver: hold a stalled request, advance on acceptance, idle in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            gap_left <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predict_corrected(in_data);
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left != 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() != 0 && !quiet_tail && $urandom_range(0, 9) == 0)
                begin
                    gap_left <= $urandom_range(0, 16);
                    in_valid <= 1'b0;
                end
                else if (sample_q.size() != 0)
                begin
                    in_data  <= sample_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, fired once partway through
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_fired <= 1'b0;
        end
        else if (!hold_fired && accepted_cnt >= HOLD_AT)
        begin
            hold_left  <= HOLD_CYCLES;
            hold_fired <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each accepted result, stall in bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen <= results_seen + 1;
                if (corrected_q.size() == 0)
                begin
                    report_fault($sformatf("result with no request pending: %h", out_data));
                end
                else
                begin
                    want_item = corrected_q.pop_front();
                    check_field("corr_accel_x", want_item.corr_accel_x, out_data.corr_accel_x);
                    check_field("corr_accel_y", want_item.corr_accel_y, out_data.corr_accel_y);
                    check_field("corr_accel_z", want_item.corr_accel_z, out_data.corr_accel_z);
                    check_field("corr_gyro_x", want_item.corr_gyro_x, out_data.corr_gyro_x);
                    check_field("corr_gyro_y", want_item.corr_gyro_y, out_data.corr_gyro_y);
                    check_field("corr_gyro_z", want_item.corr_gyro_z, out_data.corr_gyro_z);
                    check_field("calibrating", 16'(want_item.calibrating),
                                16'(out_data.calibrating));
                    check_field("calib_done", 16'(want_item.calib_done),
                                16'(out_data.calib_done));
                end
            end
            if (stall_left != 0)
            begin
                stall_left <= stall_left - 1;
                out_stall  <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                stall_left <= $urandom_range(0, 16);
                out_stall  <= 1'b1;
            end
            else
            begin
                out_stall <= (hold_left != 0);
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus sequence
    initial
    begin
        for (int i = 0; i < AXES; i++)
        begin
            sum_model[i] = 0;
            ofs_model[i] = 0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Extremes with zero offsets
        queue_item(mk(OP_SAMPLE, LANE_MAX, LANE_MIN, 16'h0000, 16'hffff, 16'h0001, LANE_MAX));
        queue_item(mk(OP_SAMPLE, LANE_MIN, LANE_MAX, 16'hffff, 16'h0000, LANE_MAX, LANE_MIN));
        drain();

        // Count written with upper bits set, largest one-g, spare index ignored
        write_reg(CFG_SAMPLE_COUNT, 15'h7c03);
        write_reg(CFG_ONE_G, 15'h7fff);
        write_reg(CFG_SPARE, 15'h0005);

        // Full-scale positive run, then saturate low
        queue_item(mk(OP_START, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX));
        queue_item(mk(OP_SAMPLE, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX));
        queue_item(mk(OP_SAMPLE, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX));
        queue_item(mk(OP_SAMPLE, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN));
        queue_item(mk(OP_SAMPLE, 16'h0000, 16'h0001, 16'h0000, 16'hffff, 16'h0000, 16'h0000));

        // Restart in the middle of a run
        queue_item(mk(OP_START, 16'h1234, 16'hedcb, 16'h4000, 16'h0100, 16'hff00, 16'h0007));
        queue_item(mk(OP_SAMPLE, 16'h0011, 16'h0022, 16'h4010, 16'h0033, 16'h0044, 16'h0055));
        queue_item(mk(OP_START, 16'h0064, 16'hff9c, 16'h3f00, 16'h0005, 16'hfffb, 16'h0000));
        queue_item(mk(OP_SAMPLE, 16'h0065, 16'hff9d, 16'h3f01, 16'h0006, 16'hfffa, 16'h0001));
        queue_item(mk(OP_SAMPLE, 16'h0063, 16'hff9a, 16'h3eff, 16'h0004, 16'hfffc, 16'hffff));

        // Full-scale negative run, then saturate high
        queue_item(mk(OP_START, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN));
        queue_item(mk(OP_SAMPLE, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN));
        queue_item(mk(OP_SAMPLE, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN, LANE_MIN));
        queue_item(mk(OP_SAMPLE, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX, LANE_MAX));
        drain();

        // Lower the count while a run is open
        write_reg(CFG_SAMPLE_COUNT, 15'd10);
        queue_item(mk(OP_START, 16'h0100, 16'h0200, 16'h4100, 16'hfff0, 16'h0010, 16'h0003));
        queue_item(mk(OP_SAMPLE, 16'h0102, 16'h01fe, 16'h4102, 16'hfff2, 16'h000e, 16'h0001));
        queue_item(mk(OP_SAMPLE, 16'h00fe, 16'h0201, 16'h40fe, 16'hffee, 16'h0012, 16'h0005));
        drain();
        write_reg(CFG_SAMPLE_COUNT, 15'd2);
        queue_item(mk(OP_SAMPLE, 16'h0101, 16'h0200, 16'h4101, 16'hfff1, 16'h0011, 16'h0002));
        drain();

        // Zero count acts as one
        set_config(0, 0);
        queue_item(mk(OP_START, 16'hfe00, 16'h0300, 16'h0050, 16'h0021, 16'hffde, 16'h7000));
        queue_item(mk(OP_SAMPLE, 16'hfe01, 16'h0301, 16'h0051, 16'h0020, 16'hffdf, 16'h7001));
        drain();

        // Short runs, random one-g; long hold-off lands in here
        set_config($urandom_range(2, 24), $urandom_range(0, 32767));
        new_bias();
        queue_runs(550, (count_shadow == 0) ? 1 : int'(count_shadow));
        drain();

        // Largest count: a long run near full scale, closed by lowering the count
        set_config(1023, 0);
        for (int i = 0; i < AXES; i++)
        begin
            bias_center[i] = 32700;
        end
        queue_item(gen_item(OP_START));
        repeat (150) queue_item(gen_item(OP_SAMPLE));
        drain();
        write_reg(CFG_SAMPLE_COUNT, 15'd7);
        repeat (3) queue_item(gen_item(OP_SAMPLE));
        drain();

        // Single-sample runs with the largest one-g
        set_config(1, 32767);
        new_bias();
        queue_runs(150, 1);
        drain();

        // Tail without idling on either side
        set_config($urandom_range(3, 40), $urandom_range(0, 32767));
        new_bias();
        quiet_tail <= 1'b1;
        queue_runs(450, int'(count_shadow));
        drain();

        if (corrected_q.size() != 0)
        begin
            report_fault($sformatf("%0d results never arrived", corrected_q.size()));
        end
        if (fault_cnt == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/sbc_pkg.sv
design/sbc_lane.sv
design/sbc_ctrl.sv
design/six_axis_bias_calibrator.sv
design/sbc_checker.sv
dv/tb_six_axis_bias_calibrator.sv
